// ===== hdl/hbf_pkg.sv =====
// Shared types and constants for the binaural FIR renderer.
`default_nettype none
package hbf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FUNC_W   = 2;
    localparam int ANGLE_W  = 7;
    localparam int TAP_W    = 8;
    localparam int CFG_W    = 9;
    localparam int DIST_W   = 9;
    localparam int DW       = 32;
    localparam int AW       = 4;

    // Register byte addresses
    localparam logic [AW-1:0] ADDR_MODE     = 4'h0;
    localparam logic [AW-1:0] ADDR_TAPCOUNT = 4'h4;
    localparam logic [AW-1:0] ADDR_ANGLE    = 4'h8;
    localparam logic [AW-1:0] ADDR_DIST     = 4'hC;

    // Input function codes
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_L = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_R = 2'd2;

    // Distance weight divider
    localparam int DEN_W = 23;
    localparam int NUM_W = 36;
    localparam int DIV_CNT_W = 6;
    localparam logic [NUM_W-1:0] NUM_BASE = 36'd65536000000;
    localparam int Q_W = 17;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_BYPASS,
        CMD_LOAD_L,
        CMD_LOAD_R
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic signed [SAMPLE_W-1:0]  sample;
        logic [ANGLE_W-1:0]          angle;
        logic [TAP_W-1:0]            tap;
        logic signed [SAMPLE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic                    mode;
        logic [CFG_W-1:0]        tap_count;
        logic signed [CFG_W-1:0] angle_deg;
        logic [DIST_W-1:0]       distance;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_BANK1,
        ST_BANK2,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE1,
        ST_SCALE2
    } eng_state_t;

endpackage
`default_nettype wire

// ===== hdl/hbf_front.sv =====
// Front end: accepts items, classifies them and queues commands for the engine.
`default_nettype none
module hbf_front #(
    parameter int MAX_TAPS   = 256,
    parameter int ANGLE_BINS = 100
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [hbf_pkg::FUNC_W-1:0]      func,
    input  wire logic signed [hbf_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic [hbf_pkg::ANGLE_W-1:0]     coef_angle,
    input  wire logic [hbf_pkg::TAP_W-1:0]       coef_tap,
    input  wire logic signed [hbf_pkg::SAMPLE_W-1:0] coef_value,
    input  wire logic                            mode,
    output logic                                 cmd_valid,
    output hbf_pkg::cmd_t                        cmd,
    input  wire logic                            cmd_pop
);
    import hbf_pkg::*;

    cmd_t       slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep;
    cmd_t       cls;
    logic       do_push, do_pop;

    // Classify; drop unused codes and out-of-range loads
    always_comb
    begin
        cls.sample = sample_in;
        cls.angle  = coef_angle;
        cls.tap    = coef_tap;
        cls.value  = coef_value;
        cls.kind   = CMD_SAMPLE;
        keep       = 1'b0;
        unique case (func)
            FUNC_SAMPLE:
            begin
                cls.kind = mode ? CMD_BYPASS : CMD_SAMPLE;
                keep     = 1'b1;
            end
            FUNC_LOAD_L, FUNC_LOAD_R:
            begin
                cls.kind = (func == FUNC_LOAD_L) ? CMD_LOAD_L : CMD_LOAD_R;
                keep     = (32'(coef_angle) < ANGLE_BINS) && (32'(coef_tap) < MAX_TAPS);
            end
            default: keep = 1'b0;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full && keep;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= cls;
    end

endmodule
`default_nettype wire

// ===== hdl/hbf_wdiv.sv =====
// Restoring divider that computes the Q0.16 distance weight.
`default_nettype none
module hbf_wdiv (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [hbf_pkg::DEN_W-1:0] den,
    output logic                           done,
    output logic [15:0]                    weight
);
    import hbf_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic                 ovf_reg, ovf_next;
    logic [DEN_W:0]       trial;
    logic                 qbit;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = DIV_CNT_W'(NUM_W - 1);
            num_next  = NUM_BASE + NUM_W'(den >> 1);
            rem_next  = '0;
            den_next  = den;
            q_next    = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], qbit};
            ovf_next = ovf_reg | q_reg[Q_W-1];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done   = done_reg;
    assign weight = (ovf_reg || q_reg[Q_W-1]) ? 16'hFFFF : q_reg[15:0];

endmodule
`default_nettype wire

// ===== hdl/hbf_engine.sv =====
// Back end: coefficient banks, delay line, shared MAC, scaling and result register.
`default_nettype none
module hbf_engine #(
    parameter int MAX_TAPS   = 256,
    parameter int ANGLE_BINS = 100
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire hbf_pkg::cfg_t                   cfg,
    input  wire logic                            cmd_valid,
    input  wire hbf_pkg::cmd_t                   cmd,
    output logic                                 cmd_pop,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic signed [hbf_pkg::SAMPLE_W-1:0]  left_out,
    output logic signed [hbf_pkg::SAMPLE_W-1:0]  right_out
);
    import hbf_pkg::*;

    localparam int PTR_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int CDEPTH = ANGLE_BINS * MAX_TAPS;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int BW     = (ANGLE_BINS > 1) ? $clog2(ANGLE_BINS) : 1;
    localparam int XW     = 9 + $clog2(ANGLE_BINS + 1);
    localparam int RSH    = 26;
    localparam longint RECIP = (longint'(1) << RSH) / 180;
    localparam int RW     = 19;
    localparam int PXW    = XW + RW;
    localparam int QW     = XW - 7;
    localparam int ACC_W  = 33 + $clog2(MAX_TAPS);
    localparam int SPW    = ACC_W + 17;

    eng_state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] dmem  [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] clmem [CDEPTH];
    logic signed [SAMPLE_W-1:0] crmem [CDEPTH];

    logic [PTR_W-1:0] wp_reg, rp_reg, wp_inc;
    logic [TW-1:0]    fill_reg, j_reg, n_tap;
    logic [CAW-1:0]   ca_reg, load_addr;
    logic signed [SAMPLE_W-1:0] samp_reg;
    logic [XW-1:0]    x_reg;
    logic [PXW-1:0]   px_reg;
    logic [11:0]      d_reg;
    logic [DEN_W-1:0] den_reg;
    logic [8:0]       mag;
    logic [QW-1:0]    q0, q1;
    logic [XW-1:0]    rem;
    logic [BW-1:0]    bank;

    logic                       s1_vld_reg, s1_tv_reg, s2_vld_reg;
    logic signed [SAMPLE_W-1:0] dl_q, cl_q, cr_q;
    logic signed [31:0]         ml_reg, mr_reg;
    logic signed [ACC_W-1:0]    accl_reg, accr_reg;
    logic signed [SPW-1:0]      pl_reg, pr_reg;
    logic signed [SPW-1:0]      rl, rr;

    logic out_vld_reg;
    logic signed [SAMPLE_W-1:0] left_reg, right_reg;

    logic        div_done;
    logic [15:0] weight;

    logic q_take, div_start, issue, out_load, out_byp, pipe_idle;

    hbf_wdiv u_wdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .den    (den_reg),
        .done   (div_done),
        .weight (weight)
    );

    assign wp_inc    = (32'(wp_reg) == MAX_TAPS - 1) ? '0 : wp_reg + 1'b1;
    assign load_addr = CAW'(32'(cmd.angle) * MAX_TAPS + 32'(cmd.tap));
    assign mag       = cfg.angle_deg[8] ? 9'(-cfg.angle_deg) : 9'(cfg.angle_deg);
    assign pipe_idle = !s1_vld_reg && !s2_vld_reg;

    always_comb
    begin
        if (cfg.tap_count == '0)
            n_tap = TW'(1);
        else if (32'(cfg.tap_count) > MAX_TAPS)
            n_tap = TW'(MAX_TAPS);
        else
            n_tap = TW'(cfg.tap_count);
    end

    // Bank = floor(x/180) by reciprocal estimate with one correction step, clamped to the last bin
    always_comb
    begin
        q0  = QW'(px_reg >> RSH);
        rem = XW'(x_reg - XW'(32'(q0) * 180));
        q1  = (rem >= XW'(180)) ? q0 + 1'b1 : q0;
        if (32'(q1) > ANGLE_BINS - 1)
            bank = BW'(ANGLE_BINS - 1);
        else
            bank = BW'(q1);
    end

    // Round half up at bit 31 and saturate
    always_comb
    begin
        rl = (pl_reg + SPW'(64'sd1 << 30)) >>> 31;
        rr = (pr_reg + SPW'(64'sd1 << 30)) >>> 31;
    end

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SPW-1:0] v);
        if (v > SPW'(32767))
            return 16'sh7FFF;
        else if (v < -SPW'(32768))
            return -16'sh8000;
        else
            return v[SAMPLE_W-1:0];
    endfunction

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_SAMPLE)
                    state_next = ST_PREP;
            end
            ST_PREP:   state_next = ST_BANK1;
            ST_BANK1:  state_next = ST_BANK2;
            ST_BANK2:  state_next = ST_MAC;
            ST_MAC:
            begin
                if (j_reg == n_tap - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (pipe_idle && div_done)
                    state_next = ST_SCALE1;
            end
            ST_SCALE1: state_next = ST_SCALE2;
            ST_SCALE2:
            begin
                if (!out_vld_reg)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        q_take    = 1'b0;
        div_start = 1'b0;
        issue     = 1'b0;
        out_load  = 1'b0;
        out_byp   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        CMD_BYPASS:
                        begin
                            q_take  = !out_vld_reg;
                            out_byp = !out_vld_reg;
                        end
                        CMD_SAMPLE, CMD_LOAD_L, CMD_LOAD_R: q_take = 1'b1;
                        default: q_take = 1'b0;
                    endcase
                end
            end
            ST_BANK2:  div_start = 1'b1;
            ST_MAC:    issue = 1'b1;
            ST_SCALE2: out_load = !out_vld_reg;
            default:   q_take = 1'b0;
        endcase
    end

    assign cmd_pop = q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
            if (state_reg == ST_PREP)
            begin
                wp_reg <= wp_inc;
                if (32'(fill_reg) < MAX_TAPS)
                    fill_reg <= fill_reg + 1'b1;
            end
            if (out_byp || out_load)
                out_vld_reg <= 1'b1;
            else if (pop)
                out_vld_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (q_take)
            samp_reg <= cmd.sample;
        if (state_reg == ST_PREP)
        begin
            rp_reg <= wp_inc;
            x_reg  <= XW'(32'(mag) * ANGLE_BINS);
            d_reg  <= 12'(12'd1000 + 12'(cfg.distance) * 12'd3);
        end
        if (state_reg == ST_BANK1)
        begin
            px_reg  <= PXW'(x_reg) * PXW'(RECIP);
            den_reg <= DEN_W'(d_reg * d_reg);
        end
        if (state_reg == ST_BANK2)
        begin
            ca_reg   <= CAW'(32'(bank) * MAX_TAPS);
            j_reg    <= '0;
            accl_reg <= '0;
            accr_reg <= '0;
        end
        if (issue)
        begin
            j_reg  <= j_reg + 1'b1;
            ca_reg <= ca_reg + 1'b1;
            rp_reg <= (rp_reg == '0) ? PTR_W'(MAX_TAPS - 1) : rp_reg - 1'b1;
        end
        s1_tv_reg <= (j_reg < fill_reg);
        ml_reg    <= (s1_tv_reg ? dl_q : 16'sd0) * cl_q;
        mr_reg    <= (s1_tv_reg ? dl_q : 16'sd0) * cr_q;
        if (s2_vld_reg)
        begin
            accl_reg <= accl_reg + ACC_W'(ml_reg);
            accr_reg <= accr_reg + ACC_W'(mr_reg);
        end
        if (state_reg == ST_SCALE1)
        begin
            pl_reg <= SPW'(accl_reg) * $signed({1'b0, weight});
            pr_reg <= SPW'(accr_reg) * $signed({1'b0, weight});
        end
        if (out_byp)
        begin
            left_reg  <= cmd.sample;
            right_reg <= cmd.sample;
        end
        else if (out_load)
        begin
            left_reg  <= sat16(rl);
            right_reg <= sat16(rr);
        end
    end

    // Delay line memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
            dmem[wp_inc] <= samp_reg;
        dl_q <= dmem[rp_reg];
    end

    // Coefficient banks
    always_ff @(posedge clk)
    begin
        if (q_take && cmd.kind == CMD_LOAD_L)
            clmem[load_addr] <= cmd.value;
        cl_q <= clmem[ca_reg];
    end

    always_ff @(posedge clk)
    begin
        if (q_take && cmd.kind == CMD_LOAD_R)
            crmem[load_addr] <= cmd.value;
        cr_q <= crmem[ca_reg];
    end

    assign empty     = !out_vld_reg;
    assign left_out  = left_reg;
    assign right_out = right_reg;

endmodule
`default_nettype wire

// ===== hdl/hrtf_binaural_fir_unit.sv =====
// Top level of the binaural FIR renderer: config registers, front end and engine.
// A spatial sample's result waits on the shared MAC pass over the n taps in use and on the
//   36-step weight divider that runs beside it.
// The engine takes no new command until a spatial sample's result is loaded; a bypass sample
//   or a coefficient load is taken from idle. A two-entry queue takes pushes meanwhile.
// Reset: asynchronous, active low; registers return to mode 0, 200 taps, angle 0,
//   distance 0, the delay line reads as zero, coefficient banks are undefined until loaded.
`default_nettype none
module hrtf_binaural_fir_unit #(
    parameter int MAX_TAPS   = 256,
    parameter int ANGLE_BINS = 100
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [hbf_pkg::FUNC_W-1:0]          func,
    input  wire logic signed [hbf_pkg::SAMPLE_W-1:0] sample_in,
    input  wire logic [hbf_pkg::ANGLE_W-1:0]         coef_angle,
    input  wire logic [hbf_pkg::TAP_W-1:0]           coef_tap,
    input  wire logic signed [hbf_pkg::SAMPLE_W-1:0] coef_value,
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [hbf_pkg::SAMPLE_W-1:0]      left_out,
    output logic signed [hbf_pkg::SAMPLE_W-1:0]      right_out,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [hbf_pkg::AW-1:0]              paddr,
    input  wire logic [hbf_pkg::DW-1:0]              pwdata,
    output logic [hbf_pkg::DW-1:0]                   prdata,
    output logic                                     pready
);
    import hbf_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  wr_en;
    logic  cmd_valid, cmd_pop;
    cmd_t  cmd;

    // Register writes complete in the access phase; pready is tied high
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr)
                ADDR_MODE:     cfg_next.mode      = pwdata[0];
                ADDR_TAPCOUNT: cfg_next.tap_count = pwdata[CFG_W-1:0];
                ADDR_ANGLE:    cfg_next.angle_deg = pwdata[CFG_W-1:0];
                ADDR_DIST:     cfg_next.distance  = pwdata[DIST_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= 1'b0;
            cfg_reg.tap_count <= CFG_W'(200);
            cfg_reg.angle_deg <= '0;
            cfg_reg.distance  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back registers zero-extended
    always_comb
    begin
        unique case (paddr)
            ADDR_MODE:     prdata = DW'(cfg_reg.mode);
            ADDR_TAPCOUNT: prdata = DW'(cfg_reg.tap_count);
            ADDR_ANGLE:    prdata = DW'(unsigned'(cfg_reg.angle_deg));
            ADDR_DIST:     prdata = DW'(cfg_reg.distance);
            default:       prdata = '0;
        endcase
    end

    // Front: take each transaction while not full, drop unused codes and out-of-range loads, queue the rest
    hbf_front #(
        .MAX_TAPS   (MAX_TAPS),
        .ANGLE_BINS (ANGLE_BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .func       (func),
        .sample_in  (sample_in),
        .coef_angle (coef_angle),
        .coef_tap   (coef_tap),
        .coef_value (coef_value),
        .mode       (cfg_reg.mode),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    // Back: run loads, bypass copies and filter passes; hold the result until popped
    hbf_engine #(
        .MAX_TAPS   (MAX_TAPS),
        .ANGLE_BINS (ANGLE_BINS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule
`default_nettype wire

// ===== hdl/hbf_checker.sv =====
// Port-level checker for the binaural FIR renderer and its bind.
`default_nettype none
module hbf_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                empty,
    input wire logic                                pop,
    input wire logic signed [hbf_pkg::SAMPLE_W-1:0] left_out,
    input wire logic signed [hbf_pkg::SAMPLE_W-1:0] right_out,
    input wire logic                                psel,
    input wire logic                                penable,
    input wire logic                                pwrite,
    input wire logic [hbf_pkg::AW-1:0]              paddr,
    input wire logic [hbf_pkg::DW-1:0]              pwdata,
    input wire logic [hbf_pkg::DW-1:0]              prdata,
    input wire logic                                pready
);
    import hbf_pkg::*;

    // Hold a waiting result until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(left_out) && $stable(right_out))
        else $error("result changed while waiting");

    a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present right after reset");

    a_mode_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == ADDR_MODE) ##1
        (psel && !pwrite && paddr == ADDR_MODE) |-> prdata[0] == $past(pwdata[0]))
        else $error("mode readback mismatch");

    a_tap_rb: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == ADDR_TAPCOUNT) ##1
        (psel && !pwrite && paddr == ADDR_TAPCOUNT) |-> prdata[8:0] == $past(pwdata[8:0]))
        else $error("tap count readback mismatch");

endmodule

bind hrtf_binaural_fir_unit hbf_checker u_hbf_checker (.*);
`default_nettype wire
